/* hw/rtl/stg_pkg.sv */
// ----------------------------------------------------------------------------
// stg_pkg
// Shared constants, codes, control structs and the quarter-wave sine table
// of the sine tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

  localparam int PHASE_BITS       = 32;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int TABLE_BITS       = $clog2(SINE_TABLE_DEPTH);

  localparam int RATE_W    = 18;
  localparam int FREQ_W    = 16;
  localparam int DUR_W     = 16;
  localparam int VOL_W     = 8;
  localparam int SAMPLE_W  = 16;
  localparam int AMP_W     = 14;
  localparam int FRAMES_W  = 24;
  localparam int ROM_W     = 16;
  localparam int Q15_SHIFT = 15;
  localparam int PCT_W     = 7;

  localparam int PROD_W     = RATE_W + DUR_W;
  localparam int STEP_DIV_W = FREQ_W + PHASE_BITS;
  localparam int DIV_W      = STEP_DIV_W;
  localparam int CNT_W      = $clog2(DIV_W);

  // frame count: 1000 = 8 * 125, divide by 125 through a reciprocal
  localparam int                 MS_PRE_SHIFT = 3;
  localparam int                 PRE_W        = PROD_W - MS_PRE_SHIFT;
  localparam int                 RECIP_W      = 32;
  localparam logic [RECIP_W-1:0] RECIP_125    = 32'd2199023256;
  localparam int                 RECIP_SHIFT  = PRE_W + 7;
  localparam int                 FQUO_W       = FRAMES_W + 1;

  localparam int RATE_RESET      = 16000;
  localparam int TONE_FULL_SCALE = 16000;
  localparam int PCT_FULL        = 100;
  localparam int AMP_PER_PCT     = TONE_FULL_SCALE / PCT_FULL;
  localparam int MS_PER_S        = 1000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_FRAME  = 2'd0,
    STATUS_IDLE   = 2'd1,
    STATUS_REJECT = 2'd2,
    STATUS_START  = 2'd3
  } status_t;

  typedef struct packed {
    logic capture;
    logic div_load_step;
    logic div_run;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic div_last;
    logic out_free;
  } dp_status_t;

  typedef logic [ROM_W-1:0] qsine_table_t [0:SINE_TABLE_DEPTH];

  function automatic logic [ROM_W-1:0] quarter_sine(input int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'(r) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32768) begin
      s = 64'd32768;
    end
    return s[ROM_W-1:0];
  endfunction

  function automatic qsine_table_t build_qsine();
    qsine_table_t tbl;
    for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      tbl[k] = quarter_sine(k);
    end
    return tbl;
  endfunction

  localparam qsine_table_t QSINE = build_qsine();

endpackage

`default_nettype wire

/* hw/rtl/sine_tone_generator.sv */
// ----------------------------------------------------------------------------
// sine_tone_generator
// Direct digital synthesis sine tone source: start words load a tone, tick
// words return one signed sample each.
// ----------------------------------------------------------------------------
// Each accepted word gives exactly one result word. A tick, or a start with
// zero frequency, goes from the idle state to the reply state, which loads
// its result into the output word register and returns to idle, where the
// next word can be taken. A valid start passes through the divide state
// first, where a bit-serial divider works out the phase step (frequency *
// 2^32 / rate), one quotient bit per cycle, while the frame count (rate
// * duration / 1000) comes from a shift by three and a reciprocal
// multiply by 1/125.
// The output word register lets the next word in while a result waits; a
// held result stalls the block until it drains. The sample rate register is
// read only when a start is taken; there is no clearing pass after reset.
`default_nettype none

module sine_tone_generator (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [stg_pkg::RATE_W-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 cmd,
  input  wire logic [stg_pkg::FREQ_W-1:0]           freq_hz,
  input  wire logic [stg_pkg::DUR_W-1:0]            tone_ms,
  input  wire logic signed [stg_pkg::VOL_W-1:0]     volume,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [stg_pkg::SAMPLE_W-1:0]       sample,
  output logic                                      last,
  output logic [1:0]                                status
);
  import stg_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t dp_stat;

  stg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (ctl)
  );

  stg_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_cmd         (cmd),
    .in_freq_hz     (freq_hz),
    .in_tone_ms     (tone_ms),
    .in_volume      (volume),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_sample     (sample),
    .out_last       (last),
    .out_status     (status),
    .cmd            (ctl),
    .stat           (dp_stat)
  );

endmodule

`default_nettype wire

/* hw/rtl/stg_ctrl.sv */
// ----------------------------------------------------------------------------
// stg_ctrl
// Sequencer of the tone generator: takes a word, steers the divider through
// the phase step of a start, then commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire stg_pkg::dp_status_t stat,
  output stg_pkg::ctl_cmd_t       cmd
);
  import stg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE     = 3'b001,
    S_DIV_STEP = 3'b010,
    S_REPLY    = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.start_ok) begin
            cmd.div_load_step = 1'b1;
            state_next        = S_DIV_STEP;
          end else begin
            state_next = S_REPLY;
          end
        end
      end
      S_DIV_STEP: begin
        cmd.div_run = 1'b1;
        if (stat.div_last) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/stg_datapath.sv */
// ----------------------------------------------------------------------------
// stg_datapath
// Tone state, bit-serial restoring divider for the phase step, reciprocal
// frame count, quarter-wave sine lookup, amplitude scaling and the output
// word register.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [stg_pkg::RATE_W-1:0]           cfg_data,
  input  wire logic                                 in_cmd,
  input  wire logic [stg_pkg::FREQ_W-1:0]           in_freq_hz,
  input  wire logic [stg_pkg::DUR_W-1:0]            in_tone_ms,
  input  wire logic signed [stg_pkg::VOL_W-1:0]     in_volume,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic signed [stg_pkg::SAMPLE_W-1:0]       out_sample,
  output logic                                      out_last,
  output logic [1:0]                                out_status,
  input  wire stg_pkg::ctl_cmd_t                    cmd,
  output stg_pkg::dp_status_t                       stat
);
  import stg_pkg::*;

  // configuration
  logic [RATE_W-1:0] rate_reg;
  logic [RATE_W-1:0] rate_eff;

  // captured word
  logic                    cmd_r;
  logic                    freq_zero_r;
  logic                    dur_zero_r;
  logic signed [VOL_W-1:0] vol_r;
  logic [PROD_W-1:0]       prod;

  // frame count
  logic [PRE_W-1:0]         prod_hi;
  logic [PRE_W+RECIP_W-1:0] recip_prod;
  logic [FQUO_W-1:0]        frames_quo;

  // divider
  logic [DIV_W-1:0]  div_acc;
  logic [RATE_W-1:0] div_rem;
  logic [RATE_W-1:0] div_den;
  logic [CNT_W-1:0]  div_cnt;
  logic [RATE_W:0]   rem_sh;
  logic [RATE_W:0]   rem_diff;
  logic              rem_ge;

  // tone state
  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_step;
  logic [AMP_W-1:0]      amplitude;
  logic [FRAMES_W-1:0]   frames_left;
  logic                  endless;
  logic                  playing;

  // lookup and scaling
  logic [TABLE_BITS-1:0]  tbl_i;
  logic [1:0]             quad;
  logic [TABLE_BITS-1:0]  r_base;
  logic [TABLE_BITS:0]    rom_idx;
  logic [ROM_W-1:0]       rom_q;
  logic [1:0]             quad_r;
  logic [AMP_W+ROM_W-1:0] mag_prod;
  logic [SAMPLE_W-1:0]    mag;
  logic [SAMPLE_W-1:0]    sample_next;

  // start values
  logic [PCT_W-1:0]    vol_pct;
  logic [FRAMES_W-1:0] frames_new;
  logic [FRAMES_W-1:0] frames_dec;
  logic                out_free;

  assign rate_eff = (rate_reg == '0) ? RATE_W'(1) : rate_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_reg <= RATE_W'(RATE_RESET);
    end else if (cfg_we) begin
      rate_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r       <= in_cmd;
      freq_zero_r <= (in_freq_hz == '0);
      dur_zero_r  <= (in_tone_ms == '0);
      vol_r       <= in_volume;
      prod        <= PROD_W'(rate_eff) * PROD_W'(in_tone_ms);
    end
  end

  // frames = (prod / 8) / 125, settled long before a start commits
  assign prod_hi    = prod[PROD_W-1:MS_PRE_SHIFT];
  assign recip_prod = (PRE_W+RECIP_W)'(prod_hi) * (PRE_W+RECIP_W)'(RECIP_125);

  always_ff @(posedge clk) begin
    frames_quo <= recip_prod[RECIP_SHIFT +: FQUO_W];
  end

  // restoring divider, one quotient bit a cycle
  assign rem_sh   = {div_rem, div_acc[DIV_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_den});
  assign rem_diff = rem_sh - {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (cmd.div_load_step) begin
      div_acc <= DIV_W'({in_freq_hz, {PHASE_BITS{1'b0}}});
      div_rem <= '0;
      div_den <= rate_eff;
      div_cnt <= CNT_W'(DIV_W - 1);
    end else if (cmd.div_run) begin
      div_acc <= {div_acc[DIV_W-2:0], rem_ge};
      div_rem <= rem_ge ? rem_diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
      div_cnt <= div_cnt - CNT_W'(1);
    end
  end

  // quarter-wave lookup, read every cycle from the current phase
  assign tbl_i   = phase[PHASE_BITS-1 -: TABLE_BITS];
  assign quad    = tbl_i[TABLE_BITS-1 -: 2];
  assign r_base  = {tbl_i[TABLE_BITS-3:0], 2'b00};
  assign rom_idx = quad[0] ? ((TABLE_BITS+1)'(SINE_TABLE_DEPTH) - {1'b0, r_base})
                           : {1'b0, r_base};

  always_ff @(posedge clk) begin
    rom_q  <= QSINE[rom_idx];
    quad_r <= quad;
  end

  assign mag_prod    = (AMP_W+ROM_W)'(amplitude) * (AMP_W+ROM_W)'(rom_q);
  assign mag         = SAMPLE_W'(mag_prod >> Q15_SHIFT);
  assign sample_next = quad_r[1] ? (SAMPLE_W'(0) - mag) : mag;

  assign vol_pct = vol_r[VOL_W-1] ? '0 :
                   (vol_r > VOL_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : vol_r[PCT_W-1:0];

  assign frames_new = (frames_quo[FQUO_W-1:FRAMES_W] != '0) ? '1
                                                            : frames_quo[FRAMES_W-1:0];
  assign frames_dec = (frames_left != '0) ? (frames_left - FRAMES_W'(1)) : frames_left;

  assign out_free = !out_valid || out_ready;

  // tone state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      phase_step  <= '0;
      amplitude   <= '0;
      frames_left <= '0;
      endless     <= 1'b0;
      playing     <= 1'b0;
    end else if (cmd.commit) begin
      if (cmd_r == CMD_START) begin
        if (!freq_zero_r) begin
          amplitude   <= AMP_W'(AMP_PER_PCT * vol_pct);
          phase_step  <= div_acc[PHASE_BITS-1:0];
          phase       <= '0;
          frames_left <= frames_new;
          endless     <= dur_zero_r;
          playing     <= dur_zero_r || (frames_new != '0);
        end
      end else if (playing) begin
        phase <= phase + phase_step;
        if (!endless) begin
          frames_left <= frames_dec;
          if (frames_dec == '0) begin
            playing <= 1'b0;
          end
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_sample <= '0;
      out_last   <= 1'b0;
      priority if (cmd_r == CMD_START && freq_zero_r) begin
        out_status <= STATUS_REJECT;
      end else if (cmd_r == CMD_START) begin
        out_status <= STATUS_START;
      end else if (!playing) begin
        out_status <= STATUS_IDLE;
      end else begin
        out_status <= STATUS_FRAME;
        out_sample <= $signed(sample_next);
        out_last   <= !endless && (frames_dec == '0);
      end
    end
  end

  assign stat.start_ok = (in_cmd == CMD_START) && (in_freq_hz != '0);
  assign stat.div_last = (div_cnt == '0);
  assign stat.out_free = out_free;

  a_commit_free : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> out_free)
    else $error("result committed while output word still held");

  a_frames_live : assert property (@(posedge clk) disable iff (rst)
    (playing && !endless) |-> (frames_left != '0))
    else $error("timed tone playing with no frames left");

  a_start_phase : assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && cmd_r == CMD_START && !freq_zero_r) |=> (phase == '0))
    else $error("phase not cleared by start");

  a_out_rise : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("output word appeared without commit");

endmodule

`default_nettype wire

/* tb/stg_tone_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stg_tone_checker
// Watches the sample rate port and both word channels of the sine tone
// generator, keeps its own copy of the tone state, works out the result word
// for every accepted input word and compares each returned word against the
// oldest one still awaited.
// ----------------------------------------------------------------------------
module stg_tone_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [stg_pkg::RATE_W-1:0]          cfg_data,
  input  wire logic                                in_valid,
  input  wire logic                                in_ready,
  input  wire logic                                cmd,
  input  wire logic [stg_pkg::FREQ_W-1:0]          freq_hz,
  input  wire logic [stg_pkg::DUR_W-1:0]           tone_ms,
  input  wire logic signed [stg_pkg::VOL_W-1:0]    volume,
  input  wire logic                                out_valid,
  input  wire logic                                out_ready,
  input  wire logic signed [stg_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                                last,
  input  wire logic [1:0]                          status,
  output int                                       mismatches,
  output int                                       pending
);
  import stg_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       fin;
    status_t                    st;
  } tone_word_t;

  tone_word_t awaited_words[$];
  tone_word_t want_w;
  tone_word_t new_w;

  logic [RATE_W-1:0]     rate_q;
  logic [PHASE_BITS-1:0] acc;
  logic [PHASE_BITS-1:0] acc_step;
  logic [AMP_W-1:0]      amp_q;
  logic [FRAMES_W-1:0]   frames_left;
  logic                  endless_q;
  logic                  playing_q;

  // quarter-wave magnitude in q15, polynomial sine of r/depth * pi/2
  function automatic logic [15:0] qsine_mag(input logic [TABLE_BITS:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    int unsigned divisor [5];
    divisor = '{110, 72, 42, 20, 6};
    x  = (64'(r) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    foreach (divisor[k]) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / divisor[k];
    end
    s = (x * t) >> 30;
    s = (s + 64'd16384) >> 15;
    return (s > 64'd32768) ? 16'h8000 : s[15:0];
  endfunction

  task automatic predict_tone_word(input logic c, input logic [FREQ_W-1:0] f,
                                   input logic [DUR_W-1:0] d,
                                   input logic [VOL_W-1:0] v,
                                   output tone_word_t w);
    logic [63:0]           rate_eff;
    logic [63:0]           vol_pct;
    logic [63:0]           frames;
    logic [TABLE_BITS-1:0] idx;
    logic [1:0]            quad;
    logic [TABLE_BITS:0]   r;
    logic [31:0]           mag;
    w.smp = '0;
    w.fin = 1'b0;
    w.st  = STATUS_IDLE;
    if (c == CMD_START) begin
      if (f == '0) begin
        w.st = STATUS_REJECT;
      end else begin
        rate_eff = (rate_q == '0) ? 64'd1 : 64'(rate_q);
        vol_pct  = v[VOL_W-1] ? 64'd0 : 64'(v[VOL_W-2:0]);
        if (vol_pct > PCT_FULL) begin
          vol_pct = PCT_FULL;
        end
        amp_q    = AMP_W'((64'(TONE_FULL_SCALE) * vol_pct) / PCT_FULL);
        acc_step = PHASE_BITS'((64'(f) << PHASE_BITS) / rate_eff);
        acc      = '0;
        frames   = (rate_eff * 64'(d)) / MS_PER_S;
        if (frames > 64'({FRAMES_W{1'b1}})) begin
          frames = 64'({FRAMES_W{1'b1}});
        end
        frames_left = frames[FRAMES_W-1:0];
        endless_q   = (d == '0);
        playing_q   = endless_q || (frames_left != '0);
        w.st        = STATUS_START;
      end
    end else if (playing_q) begin
      idx  = acc[PHASE_BITS-1 -: TABLE_BITS];
      quad = idx[TABLE_BITS-1 -: 2];
      r    = {1'b0, idx[TABLE_BITS-3:0], 2'b00};
      if (quad[0]) begin
        r = (TABLE_BITS+1)'(SINE_TABLE_DEPTH) - r;
      end
      mag   = (32'(amp_q) * 32'(qsine_mag(r))) >> Q15_SHIFT;
      w.smp = quad[1] ? -mag[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
      acc   = acc + acc_step;
      if (!endless_q) begin
        if (frames_left != '0) begin
          frames_left = frames_left - FRAMES_W'(1);
        end
        if (frames_left == '0) begin
          w.fin     = 1'b1;
          playing_q = 1'b0;
        end
      end
      w.st = STATUS_FRAME;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("%0t ns mismatch on %s: got %0d, awaited %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rate_q      = RATE_W'(RATE_RESET);
      acc         = '0;
      acc_step    = '0;
      amp_q       = '0;
      frames_left = '0;
      endless_q   = 1'b0;
      playing_q   = 1'b0;
      awaited_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch("unawaited word, status", longint'(status), -1);
        end else begin
          want_w = awaited_words.pop_front();
          if (sample !== want_w.smp) begin
            report_mismatch("sample", longint'(sample), longint'(want_w.smp));
          end
          if (last !== want_w.fin) begin
            report_mismatch("last", longint'(last), longint'(want_w.fin));
          end
          if (status !== want_w.st) begin
            report_mismatch("status", longint'(status), longint'(want_w.st));
          end
        end
      end
      if (cfg_we) begin
        rate_q = cfg_data;
      end
      if (in_valid && in_ready) begin
        predict_tone_word(cmd, freq_hz, tone_ms, volume, new_w);
        awaited_words.push_back(new_w);
      end
    end
    pending = awaited_words.size();
  end

endmodule

/* tb/tb_sine_tone_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sine_tone_generator
// Drives start and tick words into the sine tone generator over a range of
// sample rates, with random gaps on the input side and random stalls on the
// output side; the checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_sine_tone_generator;
  import stg_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int LIMIT      = 2_000_000;
  localparam int SETTLE     = 2 * DIV_W + 3 + 16;
  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 190;

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       cfg_we      = 1'b0;
  logic [RATE_W-1:0]          cfg_data    = '0;
  logic                       in_valid    = 1'b0;
  logic                       cmd         = CMD_START;
  logic [FREQ_W-1:0]          freq_hz     = '0;
  logic [DUR_W-1:0]           tone_ms     = '0;
  logic signed [VOL_W-1:0]    volume      = '0;
  logic                       out_ready   = 1'b0;
  logic                       in_ready;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic [1:0]                 status;

  int mismatches;
  int pending;
  int cycles;
  int in_gap_max    = 7;
  int out_stall_max = 7;
  int phase_words;
  int words_sent;
  int starts_sent;
  int ticks_sent;
  int rate_writes;

  logic [RATE_W-1:0] cur_rate = RATE_W'(RATE_RESET);
  logic [RATE_W-1:0] rate_plan [PHASES] = '{
    RATE_W'(RATE_RESET), RATE_W'(1), RATE_W'(0), '1, RATE_W'(192000),
    RATE_W'(44100), RATE_W'(8000), RATE_W'(48000), RATE_W'(22050), RATE_W'(16000)
  };

  always #(CLK_PERIOD / 2) clk = ~clk;

  sine_tone_generator u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .freq_hz    (freq_hz),
    .tone_ms    (tone_ms),
    .volume     (volume),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample     (sample),
    .last       (last),
    .status     (status)
  );

  stg_tone_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .freq_hz    (freq_hz),
    .tone_ms    (tone_ms),
    .volume     (volume),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample     (sample),
    .last       (last),
    .status     (status),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("run stopped after %0d cycles with %0d words awaited", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver side: random stall before each word
  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // entered and left at a falling edge
  task automatic send_word(input logic c, input logic [FREQ_W-1:0] f,
                           input logic [DUR_W-1:0] d, input logic [VOL_W-1:0] v);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd         <= c;
    freq_hz     <= f;
    tone_ms     <= d;
    volume      <= v;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
    phase_words++;
    if (c == CMD_START) begin
      starts_sent++;
    end else begin
      ticks_sent++;
    end
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, FREQ_W'($urandom), DUR_W'($urandom), VOL_W'($urandom));
  endtask

  task automatic load_rate(input logic [RATE_W-1:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    cur_rate = value;
    rate_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // start, an occasional rejected start, then a run of ticks
  task automatic tone_sequence();
    int re;
    int n;
    int durn;
    logic [FREQ_W-1:0] f;
    logic [DUR_W-1:0]  d;
    re = (cur_rate == '0) ? 1 : int'(cur_rate);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: f = FREQ_W'($urandom_range(1, 65535));
      5, 6, 7:       f = FREQ_W'($urandom_range(1, (re / 2 > 65535) ? 65535 :
                                                   (re / 2 > 1) ? re / 2 : 1));
      default:       f = FREQ_W'($urandom_range(1, 50));
    endcase
    case ($urandom_range(0, 9))
      0:       d = '0;
      1:       d = DUR_W'($urandom);
      default: begin
        n    = $urandom_range(1, 20);
        durn = (n * MS_PER_S + re - 1) / re;
        d    = DUR_W'((durn > 65535) ? 65535 : durn);
      end
    endcase
    send_word(CMD_START, f, d, VOL_W'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      send_word(CMD_START, '0, DUR_W'($urandom), VOL_W'($urandom));
    end
    repeat ($urandom_range(0, 24)) send_tick();
  endtask

  task automatic noise_word();
    logic [FREQ_W-1:0] f;
    f = ($urandom_range(0, 3) == 0) ? '0 : FREQ_W'($urandom);
    send_word(logic'($urandom_range(0, 1)), f, DUR_W'($urandom), VOL_W'($urandom));
  endtask

  initial begin
    int p;
    rate_plan[8] = RATE_W'($urandom_range(1, 192000));
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle tick, zero frequency, reject while playing, clamps, wrap, extremes
    send_tick();
    send_word(CMD_START, 16'd0, 16'd1, 8'sd50);
    send_word(CMD_START, 16'd1000, 16'd1, 8'sd100);
    repeat (3) send_tick();
    send_word(CMD_START, 16'd0, 16'd0, 8'sd100);
    repeat (2) send_tick();
    send_word(CMD_START, 16'hFFFF, 16'd0, 8'sd127);
    repeat (2) send_tick();
    send_word(CMD_START, 16'd16000, 16'd0, 8'sd101);
    send_tick();
    send_word(CMD_START, 16'd8000, 16'hFFFF, -8'sd128);
    repeat (2) send_tick();
    send_word(CMD_START, 16'd3, 16'hFFFF, 8'sd1);
    send_tick();

    for (p = 0; p < PHASES; p++) begin
      in_gap_max    = (p % 4 == 1 || p % 4 == 3) ? 0 : 7;
      out_stall_max = (p % 4 == 1 || p % 4 == 2) ? 0 : 7;
      if (p > 0) begin
        load_rate(rate_plan[p]);
      end
      // a tone left playing keeps its old step across the rate change
      repeat (2) send_tick();
      if (cur_rate == 1) begin
        send_word(CMD_START, 16'd1, 16'd999, 8'sd100);
        send_tick();
        send_word(CMD_START, 16'd1, 16'd1000, 8'sd100);
        repeat (2) send_tick();
      end else if (cur_rate == 0) begin
        send_word(CMD_START, 16'd7, 16'd0, 8'sd100);
        repeat (2) send_tick();
      end else if (cur_rate == '1) begin
        send_word(CMD_START, 16'hFFFF, 16'hFFFF, 8'sd100);
        repeat (2) send_tick();
      end
      phase_words = 0;
      while (phase_words < PHASE_LEN) begin
        if ($urandom_range(0, 99) < 15) begin
          noise_word();
        end else begin
          tone_sequence();
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("%0d words sent (%0d starts, %0d ticks) over %0d rate writes",
             words_sent, starts_sent, ticks_sent, rate_writes);
    $display("rates covered from 0 to the register maximum, with and without gaps and stalls");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
